// File: rtl/idea_pkg.sv
// ----------------------------------------------------------------------------
// idea_pkg
// Shared constants and arithmetic for the IDEA cipher unit.
// ----------------------------------------------------------------------------
package idea_pkg;

    localparam int IDEA_ROUNDS = 8;
    localparam int WORD_W      = 16;
    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 128;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

    // Multiply modulo 65537, word 0 stands for 65536.
    // 2^16 == -1 (mod 65537), so p mod 65537 = lo - hi, folded once.
    function automatic logic [15:0] idea_mulm(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] x;
        logic [16:0] y;
        logic [33:0] p;
        logic [17:0] diff;
        x    = (a == 16'd0) ? 17'h10000 : {1'b0, a};
        y    = (b == 16'd0) ? 17'h10000 : {1'b0, b};
        p    = 34'(x) * 34'(y);
        diff = {2'b00, p[15:0]} - {1'b0, p[32:16]};
        if (diff[17]) begin
            diff = diff + 18'd65537;
        end
        return diff[15:0];
    endfunction

endpackage

// File: rtl/idea_round.sv
// ----------------------------------------------------------------------------
// idea_round
// One IDEA round in three register stages with per-stage valid and ready.
// ----------------------------------------------------------------------------
module idea_round (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [idea_pkg::BLOCK_W-1:0]  in_x,
    input  logic [idea_pkg::WORD_W-1:0]   z [6],
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [idea_pkg::BLOCK_W-1:0]  out_x
);
    import idea_pkg::*;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
    } abcd_t;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic [15:0] f;
        logic [15:0] m;
    } mix_t;

    logic  va_reg, vb_reg, vc_reg;
    logic  en_a, en_b, en_c;
    abcd_t sa_reg, sa_next;
    mix_t  sb_reg, sb_next;
    logic [BLOCK_W-1:0] x_reg, x_next;
    logic [15:0] t, u;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    always_comb begin
        sa_next.a = idea_mulm(in_x[63:48], z[0]);
        sa_next.b = in_x[47:32] + z[1];
        sa_next.c = in_x[31:16] + z[2];
        sa_next.d = idea_mulm(in_x[15:0], z[3]);
    end

    always_comb begin
        sb_next.a = sa_reg.a;
        sb_next.b = sa_reg.b;
        sb_next.c = sa_reg.c;
        sb_next.d = sa_reg.d;
        sb_next.f = sa_reg.b ^ sa_reg.d;
        sb_next.m = idea_mulm(sa_reg.a ^ sa_reg.c, z[4]);
    end

    always_comb begin
        t      = idea_mulm(sb_reg.f + sb_reg.m, z[5]);
        u      = sb_reg.m + t;
        x_next = {sb_reg.a ^ t, sb_reg.c ^ t, sb_reg.b ^ u, sb_reg.d ^ u};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) begin
                va_reg <= in_valid;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
            if (en_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            sa_reg <= sa_next;
        end
        if (en_b) begin
            sb_reg <= sb_next;
        end
        if (en_c) begin
            x_reg <= x_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_x     = x_reg;

endmodule

// File: rtl/idea_keysched.sv
// ----------------------------------------------------------------------------
// idea_keysched
// Subkey store and its builder; decryption inverses by square-and-multiply.
// ----------------------------------------------------------------------------
module idea_keysched #(
    parameter int ROUNDS = idea_pkg::IDEA_ROUNDS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         decrypt,
    input  logic [idea_pkg::KEY_W-1:0]   key,
    output logic                         busy,
    output logic [idea_pkg::WORD_W-1:0]  sk [6*ROUNDS+4]
);
    import idea_pkg::*;

    localparam int NKEYS = 6 * ROUNDS + 4;
    localparam int NINV  = 2 * (ROUNDS + 1);
    localparam int KW    = $clog2(NKEYS);
    localparam int IW    = $clog2(NINV);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_INIT,
        S_SQ,
        S_MUL,
        S_WR
    } state_t;

    state_t state_reg;
    logic [15:0] ek [NKEYS];
    logic [15:0] dv [NKEYS];
    logic [15:0] sk_reg [NKEYS];
    logic [15:0] acc_reg, src_reg;
    logic [3:0]  cnt_reg;
    logic [IW-1:0] idx_reg;
    logic [KW-1:0] pos, src_idx;

    // Encryption words: key rotated left 25 bits per group of eight.
    for (genvar k = 0; k < NKEYS; k++) begin : g_ek
        localparam int W   = k % 8;
        localparam int ROT = (25 * (k / 8)) % 128;
        logic [KEY_W-1:0] rk;
        assign rk    = (key << ROT) | (key >> (KEY_W - ROT));
        assign ek[k] = rk[KEY_W-1-16*W -: 16];
    end

    // Decryption order; inverse slots are patched by the sequencer.
    for (genvar k = 0; k < NKEYS; k++) begin : g_dv
        localparam int R = k / 6;
        localparam int J = k % 6;
        localparam int S = 6 * (ROUNDS - R);
        if (J == 0 || J == 3) begin : g_inv
            assign dv[k] = ek[S+J];
        end else if (J == 1) begin : g_n1
            if (R == 0 || R == ROUNDS) begin : g_edge
                assign dv[k] = 16'd0 - ek[S+1];
            end else begin : g_mid
                assign dv[k] = 16'd0 - ek[S+2];
            end
        end else if (J == 2) begin : g_n2
            if (R == 0 || R == ROUNDS) begin : g_edge
                assign dv[k] = 16'd0 - ek[S+2];
            end else begin : g_mid
                assign dv[k] = 16'd0 - ek[S+1];
            end
        end else begin : g_mx
            localparam int P = 6 * (ROUNDS - 1 - R) + J;
            assign dv[k] = ek[P];
        end
    end

    assign pos     = KW'(6) * KW'(idx_reg >> 1) + (idx_reg[0] ? KW'(3) : KW'(0));
    assign src_idx = KW'(6) * (KW'(ROUNDS) - KW'(idx_reg >> 1))
                   + (idx_reg[0] ? KW'(3) : KW'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else if (start) begin
            state_reg <= S_LOAD;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    idx_reg   <= '0;
                    state_reg <= decrypt ? S_INIT : S_IDLE;
                end
                S_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    cnt_reg   <= cnt_reg + 4'd1;
                    state_reg <= (cnt_reg == 4'd15) ? S_WR : S_SQ;
                end
                S_WR: begin
                    idx_reg   <= idx_reg + IW'(1);
                    state_reg <= (idx_reg == IW'(NINV - 1)) ? S_IDLE : S_INIT;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a^65535: acc = acc^2 * a, sixteen times
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_INIT: begin
                acc_reg <= 16'd1;
                src_reg <= ek[src_idx];
            end
            S_SQ: begin
                acc_reg <= idea_mulm(acc_reg, acc_reg);
            end
            S_MUL: begin
                acc_reg <= idea_mulm(acc_reg, src_reg);
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NKEYS; k++) begin
            if (state_reg == S_LOAD && !start) begin
                sk_reg[k] <= decrypt ? dv[k] : ek[k];
            end else if (state_reg == S_WR && !start && pos == KW'(k)) begin
                sk_reg[k] <= acc_reg;
            end
        end
    end

    assign busy = start || (state_reg != S_IDLE);
    assign sk   = sk_reg;

endmodule

// File: rtl/idea_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// idea_block_cipher_unit
// IDEA 64-bit block cipher with 128-bit key, pipelined one round per 3 stages.
// ----------------------------------------------------------------------------
// Each round takes three register stages and the output transform one more.
// One block enters per cycle while the output side keeps up and no subkey
// rebuild is under way.
// Every stage has its own valid bit and local ready, so bubbles close up and
// a stalled output register still lets earlier stages take new beats. After
// reset and after every write to the key or mode register the subkey store
// is rebuilt, and s_ready stays low meanwhile: in encrypt mode the store is
// loaded directly; in decrypt mode the 2*(ROUNDS+1) multiplicative inverses
// are then found one at a time by square-and-multiply in the key scheduler.
// Write the key and mode only while no
// block is in flight.
// ----------------------------------------------------------------------------
module idea_block_cipher_unit #(
    parameter int ROUNDS = idea_pkg::IDEA_ROUNDS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [idea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [idea_pkg::BLOCK_W-1:0]    cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [idea_pkg::BLOCK_W-1:0]    s_data_block,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [idea_pkg::BLOCK_W-1:0]    m_result_block
);
    import idea_pkg::*;

    localparam int NKEYS = 6 * ROUNDS + 4;

    // configuration registers
    logic [63:0] key_upper_reg, key_lower_reg;
    logic        decrypt_mode_reg;
    logic        start_reg;
    logic        sched_busy;
    logic [15:0] sk [NKEYS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg    <= '0;
            key_lower_reg    <= '0;
            decrypt_mode_reg <= 1'b0;
            start_reg        <= 1'b1;   // build the all-zero key schedule
        end else begin
            start_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_KEY_UPPER: begin
                        key_upper_reg <= cfg_wdata;
                        start_reg     <= 1'b1;
                    end
                    CFG_KEY_LOWER: begin
                        key_lower_reg <= cfg_wdata;
                        start_reg     <= 1'b1;
                    end
                    CFG_DECRYPT_MODE: begin
                        decrypt_mode_reg <= cfg_wdata[0];
                        start_reg        <= 1'b1;
                    end
                    default: begin
                        start_reg <= 1'b0;  // unknown index: ignored
                    end
                endcase
            end
        end
    end

    idea_keysched #(.ROUNDS(ROUNDS)) u_keysched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .decrypt (decrypt_mode_reg),
        .key     ({key_upper_reg, key_lower_reg}),
        .busy    (sched_busy),
        .sk      (sk)
    );

    // round chain: rv/rr/rx[i] feed round i, index ROUNDS feeds the output stage
    logic              rv [ROUNDS+1];
    logic              rr [ROUNDS+1];
    logic [BLOCK_W-1:0] rx [ROUNDS+1];

    assign rv[0]   = s_valid && !sched_busy;
    assign rx[0]   = s_data_block;
    assign s_ready = rr[0] && !sched_busy;

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        logic [15:0] z [6];
        for (genvar j = 0; j < 6; j++) begin : g_z
            assign z[j] = sk[6*r+j];
        end
        idea_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (rv[r]),
            .in_ready  (rr[r]),
            .in_x      (rx[r]),
            .z         (z),
            .out_valid (rv[r+1]),
            .out_ready (rr[r+1]),
            .out_x     (rx[r+1])
        );
    end

    // output transform; note the middle words swap back
    logic               out_v_reg;
    logic [BLOCK_W-1:0] out_reg, out_next;
    logic [BLOCK_W-1:0] xl;

    assign xl = rx[ROUNDS];
    assign rr[ROUNDS] = !out_v_reg || m_ready;

    always_comb begin
        out_next = {idea_mulm(xl[63:48], sk[6*ROUNDS]),
                    xl[31:16] + sk[6*ROUNDS+1],
                    xl[47:32] + sk[6*ROUNDS+2],
                    idea_mulm(xl[15:0], sk[6*ROUNDS+3])};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (rr[ROUNDS]) begin
            out_v_reg <= rv[ROUNDS];
        end
    end

    always_ff @(posedge aclk) begin
        if (rr[ROUNDS]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = out_v_reg;
    assign m_result_block = out_reg;

    // a write to the key or mode register holds off input beats while the schedule rebuilds
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index == CFG_KEY_UPPER || cfg_index == CFG_KEY_LOWER ||
                   cfg_index == CFG_DECRYPT_MODE) |=> !s_ready)
        else $error("input beat possible right after a register write");

    // reset always starts a schedule build
    a_reset_builds: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // a new result only comes from a valid last round
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(rv[ROUNDS]))
        else $error("result beat without a valid last round");

endmodule

// File: dv/idea_block_cipher_unit_tb.sv
// ----------------------------------------------------------------------------
// idea_block_cipher_unit_tb
// Self-checking bench for the IDEA cipher unit: directed and random blocks in
// encrypt and decrypt mode under several keys, checked against a behavioral
// cipher with its own subkey schedule, with random stalls on both sides.
// ----------------------------------------------------------------------------
module idea_block_cipher_unit_tb;
    import idea_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSUB        = 6 * IDEA_ROUNDS + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_AT     = 450;   // result count that starts the long stall
    localparam int HOLD_CYCLES = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BLOCK_W-1:0]   cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BLOCK_W-1:0]   s_data_block = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BLOCK_W-1:0]   m_result_block;

    idea_block_cipher_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_block  (s_data_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_block(m_result_block)
    );

    always #5 aclk = ~aclk;

    // Bench copy of key, mode and schedule
    logic [63:0] key_hi, key_lo;
    logic        dec_mode;
    logic [15:0] sched [NSUB];

    logic [BLOCK_W-1:0] pending_blocks [$];
    logic [BLOCK_W-1:0] expected_blocks [$];
    int  errors = 0;
    int  cycles = 0;
    int  rx_count = 0;

    function automatic logic [15:0] mul_mod(logic [15:0] a, logic [15:0] b);
        logic [32:0] x, y, p;
        x = (a == 0) ? 33'd65536 : {17'd0, a};
        y = (b == 0) ? 33'd65536 : {17'd0, b};
        p = (x * y) % 33'd65537;
        return p[15:0];
    endfunction

    function automatic logic [15:0] inv_mod(logic [15:0] a);
        logic [15:0] r, b;
        r = 16'd1;
        b = a;
        for (int i = 0; i < 16; i++) begin
            r = mul_mod(r, b);   // exponent 65535 is all ones
            b = mul_mod(b, b);
        end
        return r;
    endfunction

    function automatic void build_sched();
        logic [15:0]  ek [NSUB];
        logic [127:0] k;
        k = {key_hi, key_lo};
        for (int i = 0; i < NSUB; i++) begin
            if (i % 8 == 0 && i != 0) k = {k[102:0], k[127:103]};
            ek[i] = k[127 - 16 * (i % 8) -: 16];
        end
        if (!dec_mode) begin
            for (int i = 0; i < NSUB; i++) sched[i] = ek[i];
            return;
        end
        for (int r = 0; r <= IDEA_ROUNDS; r++) begin
            int s;
            s = 6 * (IDEA_ROUNDS - r);
            sched[6*r]   = inv_mod(ek[s]);
            // outer rounds keep the add keys in place, inner ones swap them
            if (r == 0 || r == IDEA_ROUNDS) begin
                sched[6*r+1] = -ek[s+1];
                sched[6*r+2] = -ek[s+2];
            end else begin
                sched[6*r+1] = -ek[s+2];
                sched[6*r+2] = -ek[s+1];
            end
            sched[6*r+3] = inv_mod(ek[s+3]);
            if (r < IDEA_ROUNDS) begin
                sched[6*r+4] = ek[6*(IDEA_ROUNDS-1-r)+4];
                sched[6*r+5] = ek[6*(IDEA_ROUNDS-1-r)+5];
            end
        end
    endfunction

    function automatic logic [63:0] cipher_block(logic [63:0] blk);
        logic [15:0] x1, x2, x3, x4, a, b, c, d, e, f, t, u, m;
        {x1, x2, x3, x4} = blk;
        for (int r = 0; r < IDEA_ROUNDS; r++) begin
            a = mul_mod(x1, sched[6*r]);
            b = x2 + sched[6*r+1];
            c = x3 + sched[6*r+2];
            d = mul_mod(x4, sched[6*r+3]);
            e = a ^ c;
            f = b ^ d;
            m = mul_mod(e, sched[6*r+4]);
            t = mul_mod(f + m, sched[6*r+5]);
            u = m + t;
            x1 = a ^ t;
            x2 = c ^ t;
            x3 = b ^ u;
            x4 = d ^ u;
        end
        return {mul_mod(x1, sched[6*IDEA_ROUNDS]), 16'(x3 + sched[6*IDEA_ROUNDS+1]),
                16'(x2 + sched[6*IDEA_ROUNDS+2]), mul_mod(x4, sched[6*IDEA_ROUNDS+3])};
    endfunction

    // Set at the edge that took a beat, seen by the driver at the next negedge
    bit beat_taken = 1'b0;

    // Driver: one beat per queued block, random gap before each
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || beat_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_blocks.size() > 0) begin
                    s_data_block <= pending_blocks.pop_front();
                    s_valid      <= 1'b1;
                    send_gap     <= $urandom_range(0, 7);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Input beats are predicted at the edge they are accepted
    always @(posedge aclk) begin
        beat_taken <= s_valid && s_ready;
        if (s_valid && s_ready) expected_blocks.push_back(cipher_block(s_data_block));
    end

    // Receiver stall pattern; one long hold-off so the pipeline fills and backs up
    int recv_gap  = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && rx_count == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (m_valid) recv_gap <= $urandom_range(0, 7);
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            rx_count++;
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, m_result_block);
                errors++;
            end else begin
                logic [63:0] want;
                want = expected_blocks.pop_front();
                if (m_result_block !== want) begin
                    $display("%0t: result_block mismatch expected %h actual %h",
                             $realtime, want, m_result_block);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_UPPER:    key_hi = val;
            CFG_KEY_LOWER:    key_lo = val;
            CFG_DECRYPT_MODE: dec_mode = val[0];
            default: ;
        endcase
        build_sched();
    endtask

    task automatic set_key(logic [63:0] hi, logic [63:0] lo, logic md);
        write_reg(CFG_KEY_UPPER, hi);
        write_reg(CFG_KEY_LOWER, lo);
        write_reg(CFG_DECRYPT_MODE, {63'd0, md});
    endtask

    // Wait until every queued block went in and came out, plus pipeline slack
    task automatic drain();
        while (pending_blocks.size() > 0 || s_valid || expected_blocks.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: pending_blocks.push_back({$urandom_range(0, 1) ? 16'h0 : 16'hffff,
                                             16'($urandom), 16'($urandom),
                                             $urandom_range(0, 1) ? 16'h0 : 16'h1});
                default: pending_blocks.push_back({$urandom, $urandom});
            endcase
        end
    endtask

    initial begin
        key_hi = '0;
        key_lo = '0;
        dec_mode = 1'b0;
        build_sched();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: key never written (all zero), zero operands and extremes
        pending_blocks.push_back(64'h0);
        pending_blocks.push_back(64'hffff_ffff_ffff_ffff);
        pending_blocks.push_back(64'h0000_0001_0000_0001);
        pending_blocks.push_back(64'h8000_0000_0000_8000);
        pending_blocks.push_back(64'h0001_0002_0003_0004);
        drain();

        // Unknown register index is ignored by the block
        write_reg(CFG_UNUSED_IDX, 64'hffff_ffff_ffff_ffff);
        set_key(64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 1'b0);
        pending_blocks.push_back(64'h0000_0001_0002_0003);
        pending_blocks.push_back(64'h0);
        pending_blocks.push_back(64'hffff_ffff_ffff_ffff);
        drain();
        set_key(64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 1'b1);
        pending_blocks.push_back(64'h11fb_ed2b_0198_6de5);
        pending_blocks.push_back(64'h0);
        pending_blocks.push_back(64'hffff_ffff_ffff_ffff);
        drain();
        // Zero key in decrypt mode (inverse of zero), then all-ones key in encrypt mode
        set_key(64'h0, 64'h0, 1'b1);
        pending_blocks.push_back(64'h0);
        pending_blocks.push_back(64'h0123_4567_89ab_cdef);
        drain();
        set_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
        pending_blocks.push_back(64'h0);
        pending_blocks.push_back(64'hffff_0000_ffff_0000);
        drain();

        // Random phases, alternating modes with random keys
        for (int ph = 0; ph < 8; ph++) begin
            set_key({$urandom, $urandom}, {$urandom, $urandom}, ph[0]);
            queue_random(210);
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
